// File: src/cca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cca_pkg
// Shared types and constants for the clock, calendar and alarm core.
// ----------------------------------------------------------------------------
package cca_pkg;

    // Field widths.
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DATE_W  = 5;
    localparam int MONTH_W = 4;
    localparam int WDAY_W  = 7;
    localparam int OP_W    = 2;
    localparam int LEVEL_W = 3;
    localparam int BL_W    = 2;
    localparam int BLINK_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Event codes.
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_PRESS = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HOUR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_MINUTE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_DAYS   = 2'd2;

    // Counter limits.
    localparam logic [SEC_W-1:0]   SEC_TOP   = 6'd59;
    localparam logic [MIN_W-1:0]   MIN_TOP   = 6'd59;
    localparam logic [HOUR_W-1:0]  HOUR_TOP  = 5'd23;
    localparam logic [DATE_W-1:0]  DATE_TOP  = 5'd31;
    localparam logic [MONTH_W-1:0] MONTH_TOP = 4'd12;
    localparam logic [WDAY_W-1:0]  SUNDAY    = 7'd64;
    localparam logic [BLINK_W-1:0] BLINK_START     = 3'd7;
    localparam logic [BL_W-1:0]    BACKLIGHT_TICKS = 2'd3;

    // Refresh levels.
    localparam logic [LEVEL_W-1:0] LVL_SECOND = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_MINUTE = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_HOUR   = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_DATE   = 3'd4;

    // Clock and lamp state.
    typedef struct packed {
        logic [SEC_W-1:0]   seconds;
        logic [MIN_W-1:0]   minutes;
        logic [HOUR_W-1:0]  hours;
        logic [DATE_W-1:0]  day_of_month;
        logic [MONTH_W-1:0] month_number;
        logic [WDAY_W-1:0]  weekday_onehot;
        logic [BL_W-1:0]    backlight_count;
        logic [BLINK_W-1:0] blink_count;
        logic               lamp_on;
    } clk_state_t;

    // Values taken on a load event.
    typedef struct packed {
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DATE_W-1:0]  date;
        logic [MONTH_W-1:0] month;
        logic [WDAY_W-1:0]  weekday;
    } load_t;

    // Alarm settings.
    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [WDAY_W-1:0] days;
    } alarm_cfg_t;

    // One result item.
    typedef struct packed {
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DATE_W-1:0]  date;
        logic [MONTH_W-1:0] month;
        logic [WDAY_W-1:0]  weekday;
        logic               lamp_lit;
        logic               alarm_fired;
        logic [LEVEL_W-1:0] refresh_level;
    } result_t;

endpackage
`default_nettype wire

// File: src/cca_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cca_step
// Next-state and result logic for one event: tick, load or press; an unused code holds the state.
// ----------------------------------------------------------------------------
module cca_step
    import cca_pkg::*;
(
    input  wire clk_state_t cur,
    input  wire logic [OP_W-1:0] opcode,
    input  wire load_t      load,
    input  wire alarm_cfg_t alarm,
    output clk_state_t      nxt,
    output result_t         res
);

    clk_state_t tick_st;
    logic [LEVEL_W-1:0] tick_level;
    logic               tick_fired;
    logic [WDAY_W-1:0]  wday_shift;
    logic [BLINK_W-1:0] blink_arm;
    logic [BLINK_W-1:0] blink_dec;
    logic [LEVEL_W-1:0] level;
    logic               fired;

    assign wday_shift = cur.weekday_onehot >> 1;

    // Cascaded time counters and alarm check for a one-second tick.
    always_comb
    begin
        tick_st    = cur;
        tick_level = LVL_SECOND;
        tick_fired = 1'b0;
        if (cur.seconds < SEC_TOP)
        begin
            tick_st.seconds = cur.seconds + 1'b1;
        end
        else
        begin
            tick_st.seconds = '0;
            tick_level      = LVL_MINUTE;
            if (cur.minutes < MIN_TOP)
            begin
                tick_st.minutes = cur.minutes + 1'b1;
            end
            else
            begin
                tick_st.minutes = '0;
                tick_level      = LVL_HOUR;
                if (cur.hours < HOUR_TOP)
                begin
                    tick_st.hours = cur.hours + 1'b1;
                end
                else
                begin
                    tick_st.hours = '0;
                    tick_level    = LVL_DATE;
                    if (cur.day_of_month < DATE_TOP)
                    begin
                        tick_st.day_of_month = cur.day_of_month + 1'b1;
                    end
                    else
                    begin
                        tick_st.day_of_month = DATE_W'(1);
                        tick_st.month_number = (cur.month_number < MONTH_TOP) ?
                            cur.month_number + 1'b1 : MONTH_W'(1);
                    end
                    tick_st.weekday_onehot = (wday_shift == '0) ? SUNDAY : wday_shift;
                end
            end
            tick_fired = ((alarm.days & tick_st.weekday_onehot) != '0) &&
                         (tick_st.hours == alarm.hour) &&
                         (tick_st.minutes == alarm.minute);
        end

        // Backlight timeout, then blink sequencing.
        if (cur.backlight_count != '0)
        begin
            tick_st.backlight_count = cur.backlight_count - 1'b1;
            if (cur.backlight_count == BL_W'(1))
            begin
                tick_st.lamp_on = 1'b0;
            end
        end
        blink_arm = tick_fired ? BLINK_START : cur.blink_count;
        blink_dec = blink_arm - 1'b1;
        if (blink_arm != '0)
        begin
            tick_st.blink_count = blink_dec;
            if (blink_dec != '0)
            begin
                tick_st.lamp_on = ~blink_dec[0];
            end
        end
        else
        begin
            tick_st.blink_count = blink_arm;
        end
    end

    // Event selection.
    always_comb
    begin
        nxt   = cur;
        level = LVL_SECOND;
        fired = 1'b0;
        unique case (opcode)
            OP_TICK:
            begin
                nxt   = tick_st;
                level = tick_level;
                fired = tick_fired;
            end
            OP_LOAD:
            begin
                nxt.seconds        = load.second;
                nxt.minutes        = load.minute;
                nxt.hours          = load.hour;
                nxt.day_of_month   = load.date;
                nxt.month_number   = load.month;
                nxt.weekday_onehot = load.weekday;
                level              = LVL_DATE;
            end
            OP_PRESS:
            begin
                nxt.lamp_on         = 1'b1;
                nxt.backlight_count = BACKLIGHT_TICKS;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    // Result item built from the updated state.
    always_comb
    begin
        res.second        = nxt.seconds;
        res.minute        = nxt.minutes;
        res.hour          = nxt.hours;
        res.date          = nxt.day_of_month;
        res.month         = nxt.month_number;
        res.weekday       = nxt.weekday_onehot;
        res.lamp_lit      = nxt.lamp_on;
        res.alarm_fired   = fired;
        res.refresh_level = level;
    end

endmodule
`default_nettype wire

// File: src/clock_calendar_with_alarm_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clock_calendar_with_alarm_core
// Real-time clock and calendar with a weekly alarm and an indicator lamp.
// ----------------------------------------------------------------------------
// Each input transfer is one event (one-second tick, time load or backlight
// press) and yields exactly one result transfer with the time after the event,
// the lamp state, the alarm flag and the refresh level. An event enters an
// input register; the clock state and the result register are updated from it
// once the result register is free or drains, so one event per cycle is
// sustained while the output is not stalled. The input register lets one more
// event be taken while a result waits on the output.
// Alarm registers are written through the cfg port and should only change
// while no event is in flight.
// ----------------------------------------------------------------------------
module clock_calendar_with_alarm_core
    import cca_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration writes.
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Event input.
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [OP_W-1:0]       opcode,
    input  wire logic [SEC_W-1:0]      load_second,
    input  wire logic [MIN_W-1:0]      load_minute,
    input  wire logic [HOUR_W-1:0]     load_hour,
    input  wire logic [DATE_W-1:0]     load_date,
    input  wire logic [MONTH_W-1:0]    load_month,
    input  wire logic [WDAY_W-1:0]     load_weekday,
    // Result output.
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [SEC_W-1:0]           now_second,
    output logic [MIN_W-1:0]           now_minute,
    output logic [HOUR_W-1:0]          now_hour,
    output logic [DATE_W-1:0]          now_date,
    output logic [MONTH_W-1:0]         now_month,
    output logic [WDAY_W-1:0]          now_weekday,
    output logic                       lamp_lit,
    output logic                       alarm_fired,
    output logic [LEVEL_W-1:0]         refresh_level
);

    alarm_cfg_t alarm_reg;
    clk_state_t state_reg;
    clk_state_t state_next;
    logic            in_full_reg;
    logic [OP_W-1:0] op_reg;
    load_t           load_reg;
    logic            out_valid_reg;
    result_t         res_reg;
    result_t         res_next;
    logic            advance;

    // The input register moves on when the result register is free or drains.
    assign advance  = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_full_reg || advance;

    // Alarm configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ALARM_HOUR:   alarm_reg.hour   <= cfg_data[HOUR_W-1:0];
                CFG_ALARM_MINUTE: alarm_reg.minute <= cfg_data[MIN_W-1:0];
                CFG_ALARM_DAYS:   alarm_reg.days   <= cfg_data[WDAY_W-1:0];
                default:          alarm_reg        <= alarm_reg;
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_full_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg          <= opcode;
            load_reg.second <= load_second;
            load_reg.minute <= load_minute;
            load_reg.hour   <= load_hour;
            load_reg.date   <= load_date;
            load_reg.month  <= load_month;
            load_reg.weekday <= load_weekday;
        end
    end

    // Event logic.
    cca_step u_step (
        .cur    (state_reg),
        .opcode (op_reg),
        .load   (load_reg),
        .alarm  (alarm_reg),
        .nxt    (state_next),
        .res    (res_next)
    );

    // Clock state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.seconds         <= '0;
            state_reg.minutes         <= '0;
            state_reg.hours           <= '0;
            state_reg.day_of_month    <= DATE_W'(1);
            state_reg.month_number    <= MONTH_W'(1);
            state_reg.weekday_onehot  <= SUNDAY;
            state_reg.backlight_count <= '0;
            state_reg.blink_count     <= '0;
            state_reg.lamp_on         <= 1'b0;
            out_valid_reg             <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign now_second    = res_reg.second;
    assign now_minute    = res_reg.minute;
    assign now_hour      = res_reg.hour;
    assign now_date      = res_reg.date;
    assign now_month     = res_reg.month;
    assign now_weekday   = res_reg.weekday;
    assign lamp_lit      = res_reg.lamp_lit;
    assign alarm_fired   = res_reg.alarm_fired;
    assign refresh_level = res_reg.refresh_level;

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the clock, calendar and alarm core.
// ----------------------------------------------------------------------------
// Events go in over the valid/ready input channel and are mirrored by a
// behavioral model of the clock, lamp and alarm logic kept in this file. Each
// input transfer queues the expected readout, and a monitor compares every
// output transfer with the oldest queued readout field by field. Directed
// tests cover counter rollovers, out-of-range loads, the lamp timers and the
// alarm blink. Random traffic then runs under several alarm settings, mostly
// loads placed just before the alarm minute followed by runs of ticks.
// ----------------------------------------------------------------------------
module testbench;
    import cca_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS   = 215;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [OP_W-1:0]       opcode;
    logic [SEC_W-1:0]      load_second;
    logic [MIN_W-1:0]      load_minute;
    logic [HOUR_W-1:0]     load_hour;
    logic [DATE_W-1:0]     load_date;
    logic [MONTH_W-1:0]    load_month;
    logic [WDAY_W-1:0]     load_weekday;
    logic                  out_valid;
    logic                  out_ready;
    logic [SEC_W-1:0]      now_second;
    logic [MIN_W-1:0]      now_minute;
    logic [HOUR_W-1:0]     now_hour;
    logic [DATE_W-1:0]     now_date;
    logic [MONTH_W-1:0]    now_month;
    logic [WDAY_W-1:0]     now_weekday;
    logic                  lamp_lit;
    logic                  alarm_fired;
    logic [LEVEL_W-1:0]    refresh_level;

    // Model state, alarm settings and readouts still owed by the core.
    clk_state_t  clock_model;
    alarm_cfg_t  alarm_model;
    result_t     expected_readouts[$];

    int unsigned items_sent;
    int unsigned readouts_seen;
    int unsigned mismatch_count;
    int unsigned stalled_cycles;
    bit          gaps_on;

    clock_calendar_with_alarm_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .load_second   (load_second),
        .load_minute   (load_minute),
        .load_hour     (load_hour),
        .load_date     (load_date),
        .load_month    (load_month),
        .load_weekday  (load_weekday),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .now_second    (now_second),
        .now_minute    (now_minute),
        .now_hour      (now_hour),
        .now_date      (now_date),
        .now_month     (now_month),
        .now_weekday   (now_weekday),
        .lamp_lit      (lamp_lit),
        .alarm_fired   (alarm_fired),
        .refresh_level (refresh_level)
    );

    always #6 clk = ~clk;

    // Applies one event to the model and returns the readout it produces.
    function automatic result_t apply_event(input logic [OP_W-1:0] op, input load_t ld);
        result_t            r;
        logic               fired;
        logic [LEVEL_W-1:0] lvl;
        fired = 1'b0;
        lvl   = LVL_SECOND;
        case (op)
            OP_TICK:
            begin
                // Cascaded counters; a value at or above its top rolls over.
                if (clock_model.seconds < SEC_TOP) begin
                    clock_model.seconds = clock_model.seconds + 1'b1;
                end else begin
                    clock_model.seconds = '0;
                    lvl = LVL_MINUTE;
                    if (clock_model.minutes < MIN_TOP) begin
                        clock_model.minutes = clock_model.minutes + 1'b1;
                    end else begin
                        clock_model.minutes = '0;
                        lvl = LVL_HOUR;
                        if (clock_model.hours < HOUR_TOP) begin
                            clock_model.hours = clock_model.hours + 1'b1;
                        end else begin
                            clock_model.hours = '0;
                            lvl = LVL_DATE;
                            if (clock_model.day_of_month < DATE_TOP) begin
                                clock_model.day_of_month = clock_model.day_of_month + 1'b1;
                            end else begin
                                clock_model.day_of_month = DATE_W'(1);
                                if (clock_model.month_number < MONTH_TOP)
                                    clock_model.month_number = clock_model.month_number + 1'b1;
                                else
                                    clock_model.month_number = MONTH_W'(1);
                            end
                            clock_model.weekday_onehot = clock_model.weekday_onehot >> 1;
                            if (clock_model.weekday_onehot == '0)
                                clock_model.weekday_onehot = SUNDAY;
                        end
                    end
                    // The alarm is only tested when the seconds roll over.
                    if ((alarm_model.days & clock_model.weekday_onehot) != '0 &&
                        clock_model.hours == alarm_model.hour &&
                        clock_model.minutes == alarm_model.minute) begin
                        fired = 1'b1;
                        clock_model.blink_count = BLINK_START;
                    end
                end
                // Backlight timer, then the blink sequence.
                if (clock_model.backlight_count != '0) begin
                    clock_model.backlight_count = clock_model.backlight_count - 1'b1;
                    if (clock_model.backlight_count == '0)
                        clock_model.lamp_on = 1'b0;
                end
                if (clock_model.blink_count != '0) begin
                    clock_model.blink_count = clock_model.blink_count - 1'b1;
                    if (clock_model.blink_count != '0)
                        clock_model.lamp_on = ~clock_model.blink_count[0];
                end
            end
            OP_LOAD:
            begin
                clock_model.seconds        = ld.second;
                clock_model.minutes        = ld.minute;
                clock_model.hours          = ld.hour;
                clock_model.day_of_month   = ld.date;
                clock_model.month_number   = ld.month;
                clock_model.weekday_onehot = ld.weekday;
                lvl = LVL_DATE;
            end
            OP_PRESS:
            begin
                clock_model.lamp_on         = 1'b1;
                clock_model.backlight_count = BACKLIGHT_TICKS;
            end
            default:
            begin
            end
        endcase
        r.second        = clock_model.seconds;
        r.minute        = clock_model.minutes;
        r.hour          = clock_model.hours;
        r.date          = clock_model.day_of_month;
        r.month         = clock_model.month_number;
        r.weekday       = clock_model.weekday_onehot;
        r.lamp_lit      = clock_model.lamp_on;
        r.alarm_fired   = fired;
        r.refresh_level = lvl;
        return r;
    endfunction

    // Load values at full field widths, legal or not.
    function automatic load_t random_fields();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(load_t)-1:0];
    endfunction

    function automatic load_t time_fields(input int unsigned s, m, h, d, mo, w);
        load_t f;
        f.second  = SEC_W'(s);
        f.minute  = MIN_W'(m);
        f.hour    = HOUR_W'(h);
        f.date    = DATE_W'(d);
        f.month   = MONTH_W'(mo);
        f.weekday = WDAY_W'(w);
        return f;
    endfunction

    // A legal time a few seconds before the alarm minute, before midnight or before a random minute.
    function automatic load_t near_alarm_time();
        load_t       f;
        int unsigned mark;
        if (alarm_model.hour <= HOUR_TOP && alarm_model.minute <= MIN_TOP &&
            $urandom_range(0, 3) != 0)
            mark = alarm_model.hour * 60 + alarm_model.minute;
        else if ($urandom_range(0, 1) == 0)
            mark = 0;
        else
            mark = $urandom_range(0, 1439);
        mark = (mark + 1439) % 1440;
        f.second  = SEC_W'($urandom_range(50, 59));
        f.minute  = MIN_W'(mark % 60);
        f.hour    = HOUR_W'(mark / 60);
        f.date    = ($urandom_range(0, 1) == 0) ? DATE_TOP : DATE_W'($urandom_range(1, 31));
        f.month   = MONTH_W'($urandom_range(1, 12));
        f.weekday = WDAY_W'(1) << $urandom_range(0, 6);
        return f;
    endfunction

    // Sends one event; called and left at a falling edge.
    task automatic send_event(input logic [OP_W-1:0] op, input load_t ld);
        while (gaps_on && $urandom_range(0, 99) < 8) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        load_second  <= ld.second;
        load_minute  <= ld.minute;
        load_hour    <= ld.hour;
        load_date    <= ld.date;
        load_month   <= ld.month;
        load_weekday <= ld.weekday;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        expected_readouts.push_back(apply_event(op, ld));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (expected_readouts.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes all three alarm registers once the core has gone quiet.
    task automatic set_alarm(input logic [CFG_DATA_W-1:0] hour_v, minute_v, days_v);
        logic [CFG_DATA_W-1:0] vals[3];
        logic [CFG_IDX_W-1:0]  regs[3];
        wait_results_done();
        vals = '{hour_v, minute_v, days_v};
        regs = '{CFG_ALARM_HOUR, CFG_ALARM_MINUTE, CFG_ALARM_DAYS};
        for (int i = 0; i < 3; i++) begin
            cfg_write <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        cfg_write <= 1'b0;
        alarm_model.hour   = hour_v[HOUR_W-1:0];
        alarm_model.minute = minute_v[MIN_W-1:0];
        alarm_model.days   = days_v[WDAY_W-1:0];
    endtask

    task automatic test_calendar_rollover();
        send_event(OP_TICK, random_fields());
        // Full rollover from New Year's Eve; Saturday wraps to Sunday.
        send_event(OP_LOAD, time_fields(59, 59, 23, 31, 12, 1));
        send_event(OP_TICK, random_fields());
        send_event(OP_LOAD, time_fields(59, 58, 10, 5, 3, 16));
        send_event(OP_TICK, random_fields());
        // Seconds, minutes and hours above their tops, date and month zero, no weekday bit.
        send_event(OP_LOAD, time_fields(63, 63, 31, 0, 0, 0));
        send_event(OP_TICK, random_fields());
        // Month above twelve and a weekday with several bits set.
        send_event(OP_LOAD, time_fields(59, 59, 23, 31, 15, 7'h55));
        send_event(OP_TICK, random_fields());
    endtask

    task automatic test_lamp_and_unused();
        send_event(OP_PRESS, random_fields());
        send_event(OP_UNUSED, random_fields());
        repeat (4) send_event(OP_TICK, random_fields());
    endtask

    task automatic test_alarm_blink();
        // Monday 07:30, with a press landing in the middle of the blink.
        set_alarm(7'd7, 7'd30, 7'd32);
        send_event(OP_LOAD, time_fields(59, 29, 7, 9, 4, 32));
        repeat (3) send_event(OP_TICK, random_fields());
        send_event(OP_PRESS, random_fields());
        repeat (5) send_event(OP_TICK, random_fields());
        // Midnight alarm on any day, hit on the new day after rollover.
        set_alarm(7'd0, 7'd0, 7'd127);
        send_event(OP_LOAD, time_fields(59, 59, 23, 31, 12, 1));
        send_event(OP_TICK, random_fields());
    endtask

    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] hours_v[6];
        logic [CFG_DATA_W-1:0] minutes_v[6];
        logic [CFG_DATA_W-1:0] days_v[6];
        int unsigned           phase_end;
        int unsigned           burst;
        int unsigned           pick;
        hours_v   = '{CFG_DATA_W'($urandom_range(0, 23)), 7'd0, 7'd23, 7'd31,
                      CFG_DATA_W'($urandom_range(0, 31)), 7'd12};
        minutes_v = '{CFG_DATA_W'($urandom_range(0, 59)), 7'd0, 7'd59, 7'd63,
                      CFG_DATA_W'($urandom_range(0, 63)), 7'd0};
        days_v    = '{CFG_DATA_W'($urandom_range(1, 127)), 7'd127, 7'd127, 7'd127,
                      CFG_DATA_W'($urandom_range(0, 127)), 7'd0};
        for (int p = 0; p < 6; p++) begin
            // One phase runs with both sides streaming back to back.
            gaps_on = (p != 2);
            set_alarm(hours_v[p], minutes_v[p], days_v[p]);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_event(OP_LOAD, near_alarm_time());
                else if (pick < 85)
                    send_event(OP_LOAD, random_fields());
                burst = $urandom_range(4, 24);
                repeat (burst) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 84)
                        send_event(OP_TICK, random_fields());
                    else if (pick < 94)
                        send_event(OP_PRESS, random_fields());
                    else if (pick < 97)
                        send_event(OP_UNUSED, random_fields());
                    else
                        send_event(OP_LOAD, random_fields());
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    // Result side stalls at random while gaps are enabled.
    always @(negedge clk) begin
        if (!gaps_on)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= 8);
    end

    task automatic check_field(input string name, input logic [7:0] want_v, got_v);
        if (got_v !== want_v) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("readout %0d, %s: expected %0d, got %0d",
                         readouts_seen, name, want_v, got_v);
        end
    endtask

    // Compares each output transfer with the oldest queued readout.
    always @(posedge clk) begin
        result_t got;
        result_t want;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            got = {now_second, now_minute, now_hour, now_date, now_month, now_weekday,
                   lamp_lit, alarm_fired, refresh_level};
            if (expected_readouts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("readout %0d arrived with nothing queued", readouts_seen);
            end else begin
                want = expected_readouts.pop_front();
                check_field("now_second", 8'(want.second), 8'(got.second));
                check_field("now_minute", 8'(want.minute), 8'(got.minute));
                check_field("now_hour", 8'(want.hour), 8'(got.hour));
                check_field("now_date", 8'(want.date), 8'(got.date));
                check_field("now_month", 8'(want.month), 8'(got.month));
                check_field("now_weekday", 8'(want.weekday), 8'(got.weekday));
                check_field("lamp_lit", 8'(want.lamp_lit), 8'(got.lamp_lit));
                check_field("alarm_fired", 8'(want.alarm_fired), 8'(got.alarm_fired));
                check_field("refresh_level", 8'(want.refresh_level), 8'(got.refresh_level));
            end
            readouts_seen++;
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk) begin
        if (stalled_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer in %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end else if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial begin
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = CFG_ALARM_HOUR;
        cfg_data       = '0;
        in_valid       = 1'b0;
        opcode         = OP_TICK;
        load_second    = '0;
        load_minute    = '0;
        load_hour      = '0;
        load_date      = '0;
        load_month     = '0;
        load_weekday   = '0;
        out_ready      = 1'b0;
        gaps_on        = 1'b1;
        items_sent     = 0;
        readouts_seen  = 0;
        mismatch_count = 0;
        stalled_cycles = 0;

        // Model state after reset.
        alarm_model                = '0;
        clock_model                = '0;
        clock_model.day_of_month   = DATE_W'(1);
        clock_model.month_number   = MONTH_W'(1);
        clock_model.weekday_onehot = SUNDAY;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_calendar_rollover();
        test_lamp_and_unused();
        test_alarm_blink();
        test_random_traffic();

        wait_results_done();
        if (mismatch_count == 0 && expected_readouts.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
